// ----- rtl/core/acrt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrt_pkg
// shared types and constants of the audio cpu register space and timers
// ----------------------------------------------------------------------------
package acrt_pkg;

   localparam int RAM_DEPTH      = 65536;
   localparam int RAM_ADDR_W     = 16;
   localparam int BOOT_ROM_BYTES = 64;
   localparam int NUM_TIMERS     = 3;
   localparam int NUM_IN_PORTS   = 6;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2,
      OP_HOST  = 2'd3
   } op_type;

   localparam logic [15:0] ROM_BASE      = 16'hFFC0;
   localparam logic [7:0]  REG_CONTROL   = 8'hF1;
   localparam logic [7:0]  REG_DSP_INDEX = 8'hF2;
   localparam logic [7:0]  REG_DSP_DATA  = 8'hF3;
   localparam logic [7:0]  REG_PORT0     = 8'hF4;
   localparam logic [7:0]  REG_PORT3     = 8'hF7;
   localparam logic [7:0]  REG_PORT4     = 8'hF8;
   localparam logic [7:0]  REG_PORT5     = 8'hF9;
   localparam logic [7:0]  REG_TARGET0   = 8'hFA;
   localparam logic [7:0]  REG_TARGET2   = 8'hFC;
   localparam logic [7:0]  REG_COUNT0    = 8'hFD;
   localparam logic [7:0]  REG_COUNT2    = 8'hFF;

   localparam logic [7:0] BOOT_IMAGE [BOOT_ROM_BYTES] = '{
      8'hcd, 8'hef, 8'hbd, 8'h20, 8'he8, 8'h00, 8'hc6, 8'h1d,
      8'hd0, 8'hfc, 8'hc6, 8'h8f, 8'haa, 8'hf4, 8'h8f, 8'hbb,
      8'hf5, 8'he8, 8'hcc, 8'h2e, 8'hf4, 8'hfd, 8'hba, 8'hf6,
      8'hda, 8'h00, 8'he4, 8'hf4, 8'hc4, 8'hf4, 8'he4, 8'hf5,
      8'hf0, 8'h19, 8'h8d, 8'h00, 8'he4, 8'hf4, 8'hd0, 8'hfc,
      8'he4, 8'hf5, 8'hd7, 8'h00, 8'hcb, 8'hf4, 8'hfc, 8'hd0,
      8'h02, 8'hab, 8'h01, 8'h7e, 8'hf4, 8'hf0, 8'hf1, 8'h10,
      8'hfa, 8'h2f, 8'hdb, 8'h1f, 8'h00, 8'h00, 8'hc0, 8'hff
   };

   // one result before the ram byte is merged in
   typedef struct packed {
      logic       from_ram;
      logic [7:0] read_data;
      logic       dsp_read_strobe;
      logic       dsp_write_strobe;
      logic [6:0] dsp_register;
      logic [7:0] dsp_write_value;
      logic       port_out_strobe;
      logic [1:0] port_out_index;
      logic [7:0] port_out_value;
   } resp_type;

endpackage

// ----- rtl/core/audio_cpu_io_registers_timers_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_cpu_io_registers_timers_core
// audio cpu address space: 64 KiB ram, boot rom overlay, i/o registers, timers
// ----------------------------------------------------------------------------
// Every request transfer (read, write, timer tick or host port write) yields
// exactly one response transfer. One request is taken per clock unless the ram
// clear runs or rsp_tready holds the pipeline; the response goes through the
// registered main ram read (or stage-one register), then the response register.
// After reset the 65536 ram bytes are cleared one per cycle; req_tready stays low.
module audio_cpu_io_registers_timers_core #(
   parameter int SLOW_PRESCALE = 128,
   parameter int FAST_PRESCALE = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // address[15:0], data[23:16], dsp_return[31:24]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[7:0], dsp_read_strobe[8], dsp_write_strobe[9], dsp_register[16:10],
   // dsp_write_value[24:17], port_out_strobe[25], port_out_index[27:26],
   // port_out_value[35:28], zero fill[39:36]
   output logic [39:0] rsp_tdata
);

   logic                            clear_busy_ff, clear_busy_in;
   logic [acrt_pkg::RAM_ADDR_W-1:0] clear_addr_ff, clear_addr_in;
   logic                            s1_valid_ff, s1_valid_in;
   acrt_pkg::resp_type              s1_resp_ff;
   logic                            out_valid_ff, out_valid_in;
   logic [39:0]                     out_tdata_ff;

   logic                            accept;
   logic                            s1_adv;
   acrt_pkg::op_type                req_op;
   logic [15:0]                     req_address;
   logic [7:0]                      req_data;
   logic [7:0]                      req_dsp_return;
   acrt_pkg::resp_type              resp;
   logic [acrt_pkg::RAM_ADDR_W-1:0] ram_addr;
   logic                            ram_wr_en;
   logic [7:0]                      ram_wr_data;
   logic                            ram_rd_en;
   logic [7:0]                      ram_rd_data;
   logic [7:0]                      merged_read;

   assign req_op         = acrt_pkg::op_type'(req_tuser);
   assign req_address    = req_tdata[15:0];
   assign req_data       = req_tdata[23:16];
   assign req_dsp_return = req_tdata[31:24];

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !clear_busy_ff && (!s1_valid_ff || s1_adv);
   assign accept     = req_tvalid && req_tready;

   acrt_regs #(
      .SLOW_PRESCALE(SLOW_PRESCALE),
      .FAST_PRESCALE(FAST_PRESCALE)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .en         (accept),
      .op         (req_op),
      .address    (req_address),
      .data       (req_data),
      .dsp_return (req_dsp_return),
      .resp       (resp)
   );

   // every cpu write lands in ram, i/o addresses included
   assign ram_addr    = clear_busy_ff ? clear_addr_ff : req_address;
   assign ram_wr_en   = clear_busy_ff || (accept && (req_op == acrt_pkg::OP_WRITE));
   assign ram_wr_data = clear_busy_ff ? 8'h00 : req_data;
   assign ram_rd_en   = accept && (req_op == acrt_pkg::OP_READ);

   acrt_ram #(
      .WIDTH(8),
      .DEPTH(acrt_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .addr    (ram_addr),
      .wr_en   (ram_wr_en),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_data (ram_rd_data)
   );

   assign clear_addr_in = clear_addr_ff + 1'b1;
   assign clear_busy_in = clear_busy_ff && (clear_addr_ff != '1);
   assign s1_valid_in   = accept || (s1_valid_ff && !s1_adv);
   assign out_valid_in  = s1_adv || (out_valid_ff && !rsp_tready);
   assign merged_read   = s1_resp_ff.from_ram ? ram_rd_data : s1_resp_ff.read_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         s1_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         if (clear_busy_ff) begin
            clear_addr_ff <= clear_addr_in;
         end
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_resp_ff <= resp;
      end
      if (s1_adv) begin
         out_tdata_ff <= {4'h0,
                          s1_resp_ff.port_out_value,
                          s1_resp_ff.port_out_index,
                          s1_resp_ff.port_out_strobe,
                          s1_resp_ff.dsp_write_value,
                          s1_resp_ff.dsp_register,
                          s1_resp_ff.dsp_write_strobe,
                          s1_resp_ff.dsp_read_strobe,
                          merged_read};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_tdata_ff;

endmodule

// ----- rtl/core/acrt_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrt_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module acrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/acrt_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acrt_regs
// i/o registers, host ports, boot rom overlay and the three timers
// ----------------------------------------------------------------------------
module acrt_regs #(
   parameter int SLOW_PRESCALE = 128,
   parameter int FAST_PRESCALE = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  acrt_pkg::op_type          op,
   input  logic [15:0]               address,
   input  logic [7:0]                data,
   input  logic [7:0]                dsp_return,
   output acrt_pkg::resp_type        resp
);

   logic       rom_visible_ff, rom_visible_in;
   logic [7:0] dsp_index_ff, dsp_index_in;
   logic [7:0] in_port_ff [acrt_pkg::NUM_IN_PORTS];
   logic [7:0] in_port_in [acrt_pkg::NUM_IN_PORTS];
   logic [7:0] prescale_ff [acrt_pkg::NUM_TIMERS];
   logic [7:0] prescale_in [acrt_pkg::NUM_TIMERS];
   logic [7:0] divider_ff  [acrt_pkg::NUM_TIMERS];
   logic [7:0] divider_in  [acrt_pkg::NUM_TIMERS];
   logic [7:0] target_ff   [acrt_pkg::NUM_TIMERS];
   logic [7:0] target_in   [acrt_pkg::NUM_TIMERS];
   logic [3:0] count_ff    [acrt_pkg::NUM_TIMERS];
   logic [3:0] count_in    [acrt_pkg::NUM_TIMERS];
   logic [2:0] timer_on_ff, timer_on_in;

   logic       io_hit;
   logic [7:0] reg_low;
   logic [2:0] port_idx;
   logic [1:0] count_idx;
   logic [1:0] target_idx;
   logic [7:0] step;

   assign io_hit     = (address[15:8] == 8'h00) && (address[7:4] == 4'hF);
   assign reg_low    = address[7:0];
   assign port_idx   = 3'(reg_low - acrt_pkg::REG_PORT0);
   assign count_idx  = 2'(reg_low - acrt_pkg::REG_COUNT0);
   assign target_idx = 2'(reg_low - acrt_pkg::REG_TARGET0);

   always_comb begin
      rom_visible_in = rom_visible_ff;
      dsp_index_in   = dsp_index_ff;
      timer_on_in    = timer_on_ff;
      in_port_in     = in_port_ff;
      prescale_in    = prescale_ff;
      divider_in     = divider_ff;
      target_in      = target_ff;
      count_in       = count_ff;
      resp           = '0;
      step           = '0;

      unique case (op)
         acrt_pkg::OP_READ: begin
            if (io_hit) begin
               unique case (reg_low) inside
                  acrt_pkg::REG_DSP_INDEX: begin
                     resp.read_data = dsp_index_ff;
                  end
                  acrt_pkg::REG_DSP_DATA: begin
                     resp.read_data       = dsp_return;
                     resp.dsp_read_strobe = 1'b1;
                     resp.dsp_register    = dsp_index_ff[6:0];
                  end
                  [acrt_pkg::REG_PORT0:acrt_pkg::REG_PORT5]: begin
                     resp.read_data = in_port_ff[port_idx];
                  end
                  [acrt_pkg::REG_COUNT0:acrt_pkg::REG_COUNT2]: begin
                     resp.read_data       = {4'h0, count_ff[count_idx]};
                     count_in[count_idx]  = 4'h0;
                  end
                  default: begin
                     resp.read_data = 8'h00;
                  end
               endcase
            end else if (rom_visible_ff && (address >= acrt_pkg::ROM_BASE)) begin
               resp.read_data = acrt_pkg::BOOT_IMAGE[address[5:0]];
            end else begin
               resp.from_ram = 1'b1;
            end
         end
         acrt_pkg::OP_WRITE: begin
            if (io_hit) begin
               unique case (reg_low) inside
                  acrt_pkg::REG_CONTROL: begin
                     for (int t = 0; t < acrt_pkg::NUM_TIMERS; t++) begin
                        if (!timer_on_ff[t] && data[t]) begin
                           divider_in[t] = 8'h00;
                           count_in[t]   = 4'h0;
                        end
                     end
                     timer_on_in = data[2:0];
                     if (data[4]) begin
                        in_port_in[0] = 8'h00;
                        in_port_in[1] = 8'h00;
                     end
                     if (data[5]) begin
                        in_port_in[2] = 8'h00;
                        in_port_in[3] = 8'h00;
                     end
                     rom_visible_in = data[7];
                  end
                  acrt_pkg::REG_DSP_INDEX: begin
                     dsp_index_in = data;
                  end
                  acrt_pkg::REG_DSP_DATA: begin
                     if (!dsp_index_ff[7]) begin
                        resp.dsp_write_strobe = 1'b1;
                        resp.dsp_register     = dsp_index_ff[6:0];
                        resp.dsp_write_value  = data;
                     end
                  end
                  [acrt_pkg::REG_PORT0:acrt_pkg::REG_PORT3]: begin
                     resp.port_out_strobe = 1'b1;
                     resp.port_out_index  = port_idx[1:0];
                     resp.port_out_value  = data;
                  end
                  acrt_pkg::REG_PORT4, acrt_pkg::REG_PORT5: begin
                     in_port_in[port_idx] = data;
                  end
                  [acrt_pkg::REG_TARGET0:acrt_pkg::REG_TARGET2]: begin
                     target_in[target_idx] = data;
                  end
                  default: begin
                     resp.read_data = 8'h00;
                  end
               endcase
            end
         end
         acrt_pkg::OP_TICK: begin
            for (int t = 0; t < acrt_pkg::NUM_TIMERS; t++) begin
               if (prescale_ff[t] == 8'h00) begin
                  prescale_in[t] = (t == 2) ? 8'(FAST_PRESCALE - 1) : 8'(SLOW_PRESCALE - 1);
                  if (timer_on_ff[t]) begin
                     step = divider_ff[t] + 8'h01;
                     if (step == target_ff[t]) begin
                        divider_in[t] = 8'h00;
                        count_in[t]   = count_ff[t] + 4'h1;
                     end else begin
                        divider_in[t] = step;
                     end
                  end
               end else begin
                  prescale_in[t] = prescale_ff[t] - 8'h01;
               end
            end
         end
         acrt_pkg::OP_HOST: begin
            in_port_in[{1'b0, address[1:0]}] = data;
         end
         default: begin
            resp = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rom_visible_ff <= 1'b1;
         dsp_index_ff   <= '0;
         timer_on_ff    <= '0;
         for (int i = 0; i < acrt_pkg::NUM_IN_PORTS; i++) begin
            in_port_ff[i] <= '0;
         end
         for (int t = 0; t < acrt_pkg::NUM_TIMERS; t++) begin
            prescale_ff[t] <= '0;
            divider_ff[t]  <= '0;
            target_ff[t]   <= '0;
            count_ff[t]    <= '0;
         end
      end else if (en) begin
         rom_visible_ff <= rom_visible_in;
         dsp_index_ff   <= dsp_index_in;
         timer_on_ff    <= timer_on_in;
         in_port_ff     <= in_port_in;
         prescale_ff    <= prescale_in;
         divider_ff     <= divider_in;
         target_ff      <= target_in;
         count_ff       <= count_in;
      end
   end

endmodule
